>>> hw/rtl/twp_pkg.sv
// ----------------------------------------------------------------------------
// Ternary weight packer package
// Widths, codes and register indexes shared by the ternary weight packer.
// ----------------------------------------------------------------------------
`default_nettype none

package twp_pkg;

  localparam int ROW_MAX_DEF    = 16384;
  localparam int BLOCK_SIZE_DEF = 256;
  localparam int CODES_PER_WORD = 16;
  localparam int LANE_W         = 4;

  localparam int WEIGHT_W   = 16;
  localparam int LEN_CFG_W  = 15;
  localparam int ROWS_CFG_W = 16;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_ADDR_W = 1;
  localparam int LEN_W      = 17;
  localparam int ROW_W      = 16;
  localparam int SLOT_W     = 10;
  localparam int WORD_W     = 32;
  localparam int SCALE_W    = 16;
  localparam int TDATA_W    = 80;

  typedef logic [1:0] code_t;

  localparam code_t CODE_ZERO = 2'b00;
  localparam code_t CODE_POS  = 2'b01;
  localparam code_t CODE_NEG  = 2'b10;

  localparam logic [CFG_ADDR_W-1:0] REG_ROW_LENGTH = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] REG_ROW_COUNT  = 1'b1;

  localparam logic KIND_WORD  = 1'b0;
  localparam logic KIND_SCALE = 1'b1;

endpackage

`default_nettype wire

>>> hw/rtl/ternary_weight_packer_unit.sv
// ----------------------------------------------------------------------------
// Ternary weight packer unit
// Packs a stream of Q1.15 weights into 2-bit ternary codes, 16 to a word,
// and reports a per-block mean absolute value of the nonzero weights.
// ----------------------------------------------------------------------------
// Usage:
// Weights enter on the in_ channel one item per handshake, in row-major order.
// Results leave on the out_ channel: a packed word (tuser low) after every
// 16 weights or at the end of a row, and a block scale (tuser high) after
// the word that closes a block of BLOCK_SIZE weights or a row. tlast marks
// the scale of the final block of the matrix.
// Inside a block, weights stream at one item per cycle unless a word-closing
// weight meets a full, stalled output register; a word result is registered
// and appears in the cycle after its closing weight. At a block end the scale
// comes from a restoring divider that resolves one quotient bit per cycle; no
// weight is taken until that scale has been loaded into the output register.
// A single output register holds one result; while it is full and stalled,
// weights that would close a word are held off, others are still taken.
// Reset restores row_length 256, row_count 1 and clears all positions and
// sums. Configuration is written through cfg_we, cfg_addr and cfg_wdata.
// ----------------------------------------------------------------------------
`default_nettype none

module ternary_weight_packer_unit #(
  parameter int ROW_MAX    = twp_pkg::ROW_MAX_DEF,
  parameter int BLOCK_SIZE = twp_pkg::BLOCK_SIZE_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_we,
  input  wire logic [twp_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  wire logic [twp_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  // weight[15:0]
  input  wire logic signed [twp_pkg::WEIGHT_W-1:0] in_tdata,
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  // row_index[15:0], slot_index[25:16], packed_word[57:26],
  // scale_value[73:58], zero fill[79:74]
  output logic [twp_pkg::TDATA_W-1:0]           out_tdata,
  // kind[0]
  output logic                                  out_tuser,
  output logic                                  out_tlast
);

  import twp_pkg::*;

  localparam int COL_W  = $clog2(ROW_MAX);
  localparam int BPOS_W = $clog2(BLOCK_SIZE);
  localparam int NBLK   = (ROW_MAX + BLOCK_SIZE - 1) / BLOCK_SIZE;
  localparam int BIDX_W = (NBLK > 1) ? $clog2(NBLK) : 1;
  localparam int SUM_W  = WEIGHT_W + $clog2(BLOCK_SIZE);
  localparam int CNT_W  = $clog2(BLOCK_SIZE + 1);
  localparam int DCNT_W = $clog2(SUM_W + 1);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_DIV   = 2'd1;
  localparam logic [1:0] ST_SCALE = 2'd2;

  logic [1:0]            state_r, state_nxt;
  logic [LEN_CFG_W-1:0]  row_length_r, row_length_nxt;
  logic [ROWS_CFG_W-1:0] row_count_r, row_count_nxt;
  logic [COL_W-1:0]      col_r, col_nxt;
  logic [ROW_W-1:0]      row_r, row_nxt;
  logic [BPOS_W-1:0]     bpos_r, bpos_nxt;
  logic [BIDX_W-1:0]     bidx_r, bidx_nxt;
  logic [WORD_W-1:0]     acc_r, acc_nxt;
  logic [SUM_W-1:0]      sum_r, sum_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;

  logic [SUM_W-1:0]      quo_r, quo_nxt;
  logic [CNT_W-1:0]      rem_r, rem_nxt;
  logic [CNT_W-1:0]      dvs_r, dvs_nxt;
  logic [DCNT_W-1:0]     dcnt_r, dcnt_nxt;

  logic [ROW_W-1:0]      pend_row_r, pend_row_nxt;
  logic [BIDX_W-1:0]     pend_blk_r, pend_blk_nxt;
  logic                  pend_last_r, pend_last_nxt;

  logic                  out_valid_r, out_valid_nxt;
  logic                  out_kind_r, out_kind_nxt;
  logic [ROW_W-1:0]      out_row_r, out_row_nxt;
  logic [SLOT_W-1:0]     out_slot_r, out_slot_nxt;
  logic [WORD_W-1:0]     out_word_r, out_word_nxt;
  logic [SCALE_W-1:0]    out_scale_r, out_scale_nxt;
  logic                  out_last_r, out_last_nxt;

  logic [LEN_W-1:0]      len_eff;
  logic [LEN_W-1:0]      rows_eff;
  logic                  row_end;
  logic                  word_end;
  logic                  block_end;
  logic                  mat_end;
  logic                  out_free;
  logic                  in_fire;
  logic                  neg;
  logic [WEIGHT_W-1:0]   mag;
  code_t                 code;
  logic [WORD_W-1:0]     word_new;
  logic [SUM_W-1:0]      sum_new;
  logic [CNT_W-1:0]      cnt_new;
  logic [CNT_W:0]        rem_sh;
  logic [CNT_W+1:0]      diff;
  logic                  ge;

  always_comb begin
    if (row_length_r == '0) begin
      len_eff = LEN_W'(1);
    end else if (LEN_W'(row_length_r) > LEN_W'(ROW_MAX)) begin
      len_eff = LEN_W'(ROW_MAX);
    end else begin
      len_eff = LEN_W'(row_length_r);
    end
    rows_eff = (row_count_r == '0) ? LEN_W'(1) : LEN_W'(row_count_r);
  end

  assign row_end   = (LEN_W'(col_r) + LEN_W'(1)) >= len_eff;
  assign word_end  = row_end || (col_r[LANE_W-1:0] == LANE_W'(CODES_PER_WORD - 1));
  assign block_end = row_end || (bpos_r == BPOS_W'(BLOCK_SIZE - 1));
  assign mat_end   = row_end && ((LEN_W'(row_r) + LEN_W'(1)) >= rows_eff);

  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = (state_r == ST_IDLE) && (out_free || !word_end);
  assign in_fire   = in_tvalid && in_tready;

  assign neg  = in_tdata[WEIGHT_W-1];
  assign mag  = neg ? (~in_tdata + WEIGHT_W'(1)) : in_tdata;
  assign code = (in_tdata == '0) ? CODE_ZERO : (neg ? CODE_NEG : CODE_POS);

  always_comb begin
    word_new = acc_r;
    word_new[2*col_r[LANE_W-1:0] +: 2] = code;
  end

  assign sum_new = sum_r + SUM_W'(mag);
  assign cnt_new = cnt_r + ((in_tdata != '0) ? CNT_W'(1) : CNT_W'(0));

  // Restoring divider step, used for every block: one quotient bit per cycle.
  assign rem_sh = {rem_r, quo_r[SUM_W-1]};
  assign diff   = {1'b0, rem_sh} - {2'b00, dvs_r};
  assign ge     = !diff[CNT_W+1];

  always_comb begin
    state_nxt      = state_r;
    row_length_nxt = row_length_r;
    row_count_nxt  = row_count_r;
    col_nxt        = col_r;
    row_nxt        = row_r;
    bpos_nxt       = bpos_r;
    bidx_nxt       = bidx_r;
    acc_nxt        = acc_r;
    sum_nxt        = sum_r;
    cnt_nxt        = cnt_r;
    quo_nxt        = quo_r;
    rem_nxt        = rem_r;
    dvs_nxt        = dvs_r;
    dcnt_nxt       = dcnt_r;
    pend_row_nxt   = pend_row_r;
    pend_blk_nxt   = pend_blk_r;
    pend_last_nxt  = pend_last_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_kind_nxt   = out_kind_r;
    out_row_nxt    = out_row_r;
    out_slot_nxt   = out_slot_r;
    out_word_nxt   = out_word_r;
    out_scale_nxt  = out_scale_r;
    out_last_nxt   = out_last_r;

    if (cfg_we) begin
      case (cfg_addr)
        REG_ROW_LENGTH: row_length_nxt = cfg_wdata[LEN_CFG_W-1:0];
        REG_ROW_COUNT:  row_count_nxt  = cfg_wdata[ROWS_CFG_W-1:0];
        default: ;
      endcase
    end

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          acc_nxt = word_new;
          sum_nxt = sum_new;
          cnt_nxt = cnt_new;
          if (word_end) begin
            out_valid_nxt = 1'b1;
            out_kind_nxt  = KIND_WORD;
            out_row_nxt   = row_r;
            out_slot_nxt  = SLOT_W'(col_r >> LANE_W);
            out_word_nxt  = word_new;
            out_scale_nxt = '0;
            out_last_nxt  = mat_end && !block_end;
            acc_nxt       = '0;
          end
          if (block_end) begin
            quo_nxt       = sum_new;
            rem_nxt       = '0;
            dvs_nxt       = cnt_new;
            dcnt_nxt      = DCNT_W'(SUM_W);
            pend_row_nxt  = row_r;
            pend_blk_nxt  = bidx_r;
            pend_last_nxt = mat_end;
            sum_nxt       = '0;
            cnt_nxt       = '0;
            state_nxt     = ST_DIV;
          end
          if (row_end) begin
            col_nxt  = '0;
            row_nxt  = mat_end ? '0 : (row_r + ROW_W'(1));
            bpos_nxt = '0;
            bidx_nxt = '0;
          end else begin
            col_nxt = col_r + COL_W'(1);
            if (block_end) begin
              bpos_nxt = '0;
              bidx_nxt = bidx_r + BIDX_W'(1);
            end else begin
              bpos_nxt = bpos_r + BPOS_W'(1);
            end
          end
        end
      end
      ST_DIV: begin
        quo_nxt  = {quo_r[SUM_W-2:0], ge};
        rem_nxt  = ge ? diff[CNT_W-1:0] : rem_sh[CNT_W-1:0];
        dcnt_nxt = dcnt_r - DCNT_W'(1);
        if (dcnt_r == DCNT_W'(1)) begin
          state_nxt = ST_SCALE;
        end
      end
      ST_SCALE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = KIND_SCALE;
          out_row_nxt   = pend_row_r;
          out_slot_nxt  = SLOT_W'(pend_blk_r);
          out_word_nxt  = '0;
          out_scale_nxt = (dvs_r == '0) ? '0 : quo_r[SCALE_W-1:0];
          out_last_nxt  = pend_last_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      row_length_r <= LEN_CFG_W'(256);
      row_count_r  <= ROWS_CFG_W'(1);
      col_r        <= '0;
      row_r        <= '0;
      bpos_r       <= '0;
      bidx_r       <= '0;
      acc_r        <= '0;
      sum_r        <= '0;
      cnt_r        <= '0;
      dcnt_r       <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      row_length_r <= row_length_nxt;
      row_count_r  <= row_count_nxt;
      col_r        <= col_nxt;
      row_r        <= row_nxt;
      bpos_r       <= bpos_nxt;
      bidx_r       <= bidx_nxt;
      acc_r        <= acc_nxt;
      sum_r        <= sum_nxt;
      cnt_r        <= cnt_nxt;
      dcnt_r       <= dcnt_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r       <= quo_nxt;
    rem_r       <= rem_nxt;
    dvs_r       <= dvs_nxt;
    pend_row_r  <= pend_row_nxt;
    pend_blk_r  <= pend_blk_nxt;
    pend_last_r <= pend_last_nxt;
    out_kind_r  <= out_kind_nxt;
    out_row_r   <= out_row_nxt;
    out_slot_r  <= out_slot_nxt;
    out_word_r  <= out_word_nxt;
    out_scale_r <= out_scale_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {(TDATA_W - ROW_W - SLOT_W - WORD_W - SCALE_W)'(0),
                       out_scale_r, out_word_r, out_slot_r, out_row_r};

  a_div_to_scale: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV && dcnt_r == DCNT_W'(1)) |=> (state_r == ST_SCALE))
    else $error("divider did not hand over to scale output");

  a_scale_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_kind_r == KIND_SCALE) |-> (out_scale_r <= SCALE_W'(32768)))
    else $error("block scale above full scale");

  a_word_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_kind_r == KIND_WORD) |-> !out_last_r)
    else $error("packed word marked as end of matrix");

  a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |=> !$rose(in_tready) || (state_r == ST_IDLE))
    else $error("input taken while divider busy");

endmodule

`default_nettype wire
